// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL of the project, included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/ecdf_pkg.sv -----
// Package with the types, constants and codes of the empirical CDF block.
package ecdf_pkg;

   // Table geometry.
   localparam int MAX_DISTINCT = 256;
   localparam int IDX_W        = $clog2(MAX_DISTINCT);
   localparam int CNT_W        = $clog2(MAX_DISTINCT + 1);

   // Field widths.
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 16;
   localparam int FRAC_W   = 17;

   // Total sample count at which further loads are refused.
   localparam logic [COUNT_W-1:0] TOTAL_LIMIT = 16'hFFFF;

   // Divider iteration count: one quotient bit per cycle.
   localparam int DIV_STEPS = 2 * COUNT_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } ecdf_op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_DONE = 2'd2
   } ecdf_status_type;

   // Which of the three points of a table entry comes next.
   typedef enum logic [1:0] {
      PH_PREV   = 2'd0,
      PH_BEFORE = 2'd1,
      PH_AFTER  = 2'd2
   } ecdf_phase_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_INS_CHK,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_RD_ADDR,
      S_RD_DATA,
      S_DIV_GO,
      S_DIV_WAIT,
      S_FINISH
   } ecdf_state_type;

   // One table entry: distinct value and its count.
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [COUNT_W-1:0] count;
   } ecdf_entry_type;

   typedef struct packed {
      logic               start;
      logic [COUNT_W-1:0] numer;
      logic [COUNT_W-1:0] denom;
   } ecdf_div_req_type;

   typedef struct packed {
      logic              done;
      logic [FRAC_W-1:0] quot;
   } ecdf_div_rsp_type;

   // Controller status and finished result toward the top level.
   typedef struct packed {
      logic               idle;
      logic               fin;
      ecdf_status_type    status;
      logic [VALUE_W-1:0] point_x;
      logic [FRAC_W-1:0]  point_y;
      logic               last_point;
   } ecdf_result_type;

endpackage

// ----- hw/rtl/ecdf_ifs.sv -----
// Valid/ready channel interfaces for requests and responses.
interface ecdf_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [ecdf_pkg::OP_W-1:0]            op;
   logic signed [ecdf_pkg::VALUE_W-1:0]  sample_value;

   modport source (output valid, output op, output sample_value, input ready);
   modport sink (input valid, input op, input sample_value, output ready);
endinterface

interface ecdf_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [ecdf_pkg::STATUS_W-1:0]        status;
   logic signed [ecdf_pkg::VALUE_W-1:0]  point_x;
   logic [ecdf_pkg::FRAC_W-1:0]          point_y;
   logic                                 last_point;

   modport source (output valid, output status, output point_x, output point_y,
                   output last_point, input ready);
   modport sink (input valid, input status, input point_x, input point_y,
                 input last_point, output ready);
endinterface

// ----- hw/rtl/ecdf_div.sv -----
// Restoring divider producing floor((numer << 16) / denom), one bit per cycle.
module ecdf_div (
   input  logic                       clock,
   input  logic                       reset,
   input  ecdf_pkg::ecdf_div_req_type div_req,
   output ecdf_pkg::ecdf_div_rsp_type div_rsp
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [ecdf_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [ecdf_pkg::DIV_STEPS-1:0]     work_ff, work_in;
   logic [ecdf_pkg::COUNT_W-1:0]       rem_ff, rem_in;
   logic [ecdf_pkg::COUNT_W-1:0]       denom_ff, denom_in;
   logic [ecdf_pkg::COUNT_W:0]         trial;
   logic [ecdf_pkg::COUNT_W:0]         diff;
   logic                               take;

   // One trial subtraction per iteration.
   always_comb begin
      trial = {rem_ff, work_ff[ecdf_pkg::DIV_STEPS-1]};
      diff  = trial - {1'b0, denom_ff};
      take  = (trial >= {1'b0, denom_ff});
   end

   // Sequencing of the iterations.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      work_in  = work_ff;
      rem_in   = rem_ff;
      denom_in = denom_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         work_in  = {div_req.numer, {ecdf_pkg::COUNT_W{1'b0}}};
         rem_in   = '0;
         denom_in = div_req.denom;
      end else if (busy_ff) begin
         work_in = {work_ff[ecdf_pkg::DIV_STEPS-2:0], take};
         rem_in  = take ? diff[ecdf_pkg::COUNT_W-1:0] : trial[ecdf_pkg::COUNT_W-1:0];
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == ecdf_pkg::DIV_CNT_W'(ecdf_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      work_ff  <= work_in;
      rem_ff   <= rem_in;
      denom_ff <= denom_in;
   end

   // A zero total yields a zero fraction.
   assign div_rsp.done = done_ff;
   assign div_rsp.quot = (denom_ff == '0) ? '0 : work_ff[ecdf_pkg::FRAC_W-1:0];

endmodule

// ----- hw/rtl/ecdf_ctrl.sv -----
// Sequencer with the sorted value table: load search and shift, point walk, clear.
module ecdf_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [ecdf_pkg::OP_W-1:0]         op,
   input  logic [ecdf_pkg::VALUE_W-1:0]      sample_value,
   input  logic                              out_free,
   output ecdf_pkg::ecdf_div_req_type        div_req,
   input  ecdf_pkg::ecdf_div_rsp_type        div_rsp,
   output ecdf_pkg::ecdf_result_type         result
);

   ecdf_pkg::ecdf_state_type            state_ff, state_in;
   ecdf_pkg::ecdf_op_type               op_ff, op_in;
   logic [ecdf_pkg::VALUE_W-1:0]        val_ff, val_in;
   logic [ecdf_pkg::CNT_W-1:0]          used_ff, used_in;
   logic [ecdf_pkg::COUNT_W-1:0]        total_ff, total_in;
   logic [ecdf_pkg::CNT_W-1:0]          cursor_ff, cursor_in;
   ecdf_pkg::ecdf_phase_type            phase_ff, phase_in;
   logic [ecdf_pkg::COUNT_W-1:0]        running_ff, running_in;
   logic [ecdf_pkg::CNT_W-1:0]          pos_ff, pos_in;
   logic [ecdf_pkg::CNT_W-1:0]          k_ff, k_in;
   ecdf_pkg::ecdf_status_type           status_ff, status_in;
   logic [ecdf_pkg::VALUE_W-1:0]        px_ff, px_in;
   logic [ecdf_pkg::FRAC_W-1:0]         py_ff, py_in;
   logic                                last_ff, last_in;

   // Table memory with registered read.
   ecdf_pkg::ecdf_entry_type            mem [ecdf_pkg::MAX_DISTINCT];
   ecdf_pkg::ecdf_entry_type            rd_data_ff;
   logic [ecdf_pkg::IDX_W-1:0]          rd_addr;
   logic                                mem_we;
   logic [ecdf_pkg::IDX_W-1:0]          wr_addr;
   ecdf_pkg::ecdf_entry_type            wr_data;

   logic                                total_full;
   logic                                table_full;
   logic                                read_over;
   logic                                rd_less;
   logic                                rd_equal;
   logic [ecdf_pkg::CNT_W-1:0]          cursor_next;
   logic [ecdf_pkg::CNT_W-1:0]          k_prev;

   // Compare and status terms.
   always_comb begin
      total_full  = (total_ff == ecdf_pkg::TOTAL_LIMIT);
      table_full  = (used_ff == ecdf_pkg::CNT_W'(ecdf_pkg::MAX_DISTINCT));
      read_over   = (cursor_ff >= used_ff);
      rd_less     = ($signed(rd_data_ff.value) < $signed(val_ff));
      rd_equal    = (rd_data_ff.value == val_ff);
      cursor_next = cursor_ff + 1'b1;
      k_prev      = k_ff - 1'b1;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ecdf_pkg::S_IDLE: begin
            if (accept) state_in = ecdf_pkg::S_DISPATCH;
         end
         ecdf_pkg::S_DISPATCH: begin
            case (op_ff)
               ecdf_pkg::OP_LOAD:
                  state_in = total_full ? ecdf_pkg::S_FINISH : ecdf_pkg::S_SRCH_RD;
               ecdf_pkg::OP_READ:
                  state_in = read_over ? ecdf_pkg::S_FINISH : ecdf_pkg::S_RD_ADDR;
               default: state_in = ecdf_pkg::S_FINISH;
            endcase
         end
         ecdf_pkg::S_SRCH_RD: begin
            state_in = (pos_ff == used_ff) ? ecdf_pkg::S_INS_CHK : ecdf_pkg::S_SRCH_CMP;
         end
         ecdf_pkg::S_SRCH_CMP: begin
            if (rd_less) state_in = ecdf_pkg::S_SRCH_RD;
            else if (rd_equal) state_in = ecdf_pkg::S_FINISH;
            else state_in = ecdf_pkg::S_INS_CHK;
         end
         ecdf_pkg::S_INS_CHK: begin
            state_in = table_full ? ecdf_pkg::S_FINISH : ecdf_pkg::S_SHIFT_RD;
         end
         ecdf_pkg::S_SHIFT_RD: begin
            state_in = (k_ff == pos_ff) ? ecdf_pkg::S_FINISH : ecdf_pkg::S_SHIFT_WR;
         end
         ecdf_pkg::S_SHIFT_WR: state_in = ecdf_pkg::S_SHIFT_RD;
         ecdf_pkg::S_RD_ADDR:  state_in = ecdf_pkg::S_RD_DATA;
         ecdf_pkg::S_RD_DATA:  state_in = ecdf_pkg::S_DIV_GO;
         ecdf_pkg::S_DIV_GO:   state_in = ecdf_pkg::S_DIV_WAIT;
         ecdf_pkg::S_DIV_WAIT: begin
            if (div_rsp.done) state_in = ecdf_pkg::S_FINISH;
         end
         ecdf_pkg::S_FINISH: begin
            if (out_free) state_in = ecdf_pkg::S_IDLE;
         end
         default: state_in = ecdf_pkg::S_IDLE;
      endcase
   end

   // Outputs of the sequencer: memory port, divider start, handshake status.
   always_comb begin
      rd_addr       = cursor_ff[ecdf_pkg::IDX_W-1:0];
      mem_we        = 1'b0;
      wr_addr       = pos_ff[ecdf_pkg::IDX_W-1:0];
      wr_data.value = val_ff;
      wr_data.count = ecdf_pkg::COUNT_W'(1);
      div_req.start = 1'b0;
      div_req.numer = running_ff;
      div_req.denom = total_ff;
      result.idle   = 1'b0;
      result.fin    = 1'b0;
      case (state_ff)
         ecdf_pkg::S_IDLE: result.idle = 1'b1;
         ecdf_pkg::S_SRCH_RD: rd_addr = pos_ff[ecdf_pkg::IDX_W-1:0];
         ecdf_pkg::S_SRCH_CMP: begin
            if (!rd_less && rd_equal) begin
               mem_we        = 1'b1;
               wr_data.value = rd_data_ff.value;
               wr_data.count = rd_data_ff.count + 1'b1;
            end
         end
         ecdf_pkg::S_SHIFT_RD: begin
            rd_addr = k_prev[ecdf_pkg::IDX_W-1:0];
            if (k_ff == pos_ff) mem_we = 1'b1;
         end
         ecdf_pkg::S_SHIFT_WR: begin
            mem_we  = 1'b1;
            wr_addr = k_ff[ecdf_pkg::IDX_W-1:0];
            wr_data = rd_data_ff;
         end
         ecdf_pkg::S_RD_ADDR: begin
            // The first point sits at the previous value; entry zero uses its own.
            if (phase_ff == ecdf_pkg::PH_PREV && cursor_ff != '0) begin
               rd_addr = cursor_ff[ecdf_pkg::IDX_W-1:0] - 1'b1;
            end
         end
         ecdf_pkg::S_DIV_GO: div_req.start = 1'b1;
         ecdf_pkg::S_FINISH: result.fin = 1'b1;
         default: ;
      endcase
   end

   // Datapath register updates.
   always_comb begin
      op_in      = op_ff;
      val_in     = val_ff;
      used_in    = used_ff;
      total_in   = total_ff;
      cursor_in  = cursor_ff;
      phase_in   = phase_ff;
      running_in = running_ff;
      pos_in     = pos_ff;
      k_in       = k_ff;
      status_in  = status_ff;
      px_in      = px_ff;
      py_in      = py_ff;
      last_in    = last_ff;
      case (state_ff)
         ecdf_pkg::S_IDLE: begin
            if (accept) begin
               op_in     = ecdf_pkg::ecdf_op_type'(op);
               val_in    = sample_value;
               status_in = ecdf_pkg::STATUS_OK;
               px_in     = '0;
               py_in     = '0;
               last_in   = 1'b0;
            end
         end
         ecdf_pkg::S_DISPATCH: begin
            case (op_ff)
               ecdf_pkg::OP_LOAD: begin
                  // Every load restarts the curve walk.
                  cursor_in  = '0;
                  phase_in   = ecdf_pkg::PH_PREV;
                  running_in = '0;
                  pos_in     = '0;
                  if (total_full) status_in = ecdf_pkg::STATUS_FULL;
               end
               ecdf_pkg::OP_READ: begin
                  if (read_over) status_in = ecdf_pkg::STATUS_DONE;
               end
               ecdf_pkg::OP_CLEAR: begin
                  used_in    = '0;
                  total_in   = '0;
                  cursor_in  = '0;
                  phase_in   = ecdf_pkg::PH_PREV;
                  running_in = '0;
               end
               default: ;
            endcase
         end
         ecdf_pkg::S_SRCH_CMP: begin
            if (rd_less) pos_in = pos_ff + 1'b1;
            else if (rd_equal) total_in = total_ff + 1'b1;
         end
         ecdf_pkg::S_INS_CHK: begin
            if (table_full) status_in = ecdf_pkg::STATUS_FULL;
            else k_in = used_ff;
         end
         ecdf_pkg::S_SHIFT_RD: begin
            if (k_ff == pos_ff) begin
               used_in  = used_ff + 1'b1;
               total_in = total_ff + 1'b1;
            end
         end
         ecdf_pkg::S_SHIFT_WR: k_in = k_prev;
         ecdf_pkg::S_RD_DATA: begin
            px_in = rd_data_ff.value;
            if (phase_ff == ecdf_pkg::PH_AFTER) running_in = running_ff + rd_data_ff.count;
         end
         ecdf_pkg::S_DIV_WAIT: begin
            if (div_rsp.done) begin
               py_in = div_rsp.quot;
               case (phase_ff)
                  ecdf_pkg::PH_PREV: phase_in = ecdf_pkg::PH_BEFORE;
                  ecdf_pkg::PH_BEFORE: begin
                     // The closing point at one is never emitted.
                     if (cursor_next == used_ff) begin
                        last_in   = 1'b1;
                        cursor_in = used_ff;
                        phase_in  = ecdf_pkg::PH_PREV;
                     end else begin
                        phase_in = ecdf_pkg::PH_AFTER;
                     end
                  end
                  default: begin
                     cursor_in = cursor_next;
                     phase_in  = ecdf_pkg::PH_PREV;
                  end
               endcase
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ecdf_pkg::S_IDLE;
         used_ff    <= '0;
         total_ff   <= '0;
         cursor_ff  <= '0;
         phase_ff   <= ecdf_pkg::PH_PREV;
         running_ff <= '0;
      end else begin
         state_ff   <= state_in;
         used_ff    <= used_in;
         total_ff   <= total_in;
         cursor_ff  <= cursor_in;
         phase_ff   <= phase_in;
         running_ff <= running_in;
      end
      op_ff     <= op_in;
      val_ff    <= val_in;
      pos_ff    <= pos_in;
      k_ff      <= k_in;
      status_ff <= status_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      last_ff   <= last_in;
   end

   // Table memory: up to one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign result.status     = status_ff;
   assign result.point_x    = px_ff;
   assign result.point_y    = py_ff;
   assign result.last_point = last_ff;

endmodule

// ----- hw/rtl/empirical_cdf_step_curve_core.sv -----
// Top level of the empirical CDF step-curve block with its response register.
//
// Requests arrive on req_if: op 0 loads a signed Q16.16 sample into a sorted
// table of up to 256 distinct values with counts, op 1 reads the next point of
// the step curve, op 2 clears the table. Every request yields exactly one
// response on rsp_if with a status and, for reads, the point (x, y, last).
// The block takes one request at a time; req_if.ready is high only while the
// sequencer is idle, and a waiting response does not block the next request.
// The sequencer returns to idle in the same cycle as its response turns valid.
// A load walks the table past each smaller entry and an insert shifts the
// higher entries up; passed plus moved is at most D for D entries, and a
// load refused at the sample limit skips both. A read runs the 32-step
// bit-serial divider that forms count * 65536 / total. Clear, unused ops
// and reads past the end go from dispatch straight to the response.
// Synchronous reset empties the table and restarts the curve walk; no
// clearing pass is needed. When the receiver stalls, the response is held in
// the output register and the sequencer waits at its end until the register
// is free.
module empirical_cdf_step_curve_core (
   input  logic       clock,
   input  logic       reset,
   ecdf_req_if.sink   req_if,
   ecdf_rsp_if.source rsp_if
);

`include "assert_macros.svh"

   ecdf_pkg::ecdf_div_req_type          div_req;
   ecdf_pkg::ecdf_div_rsp_type          div_rsp;
   ecdf_pkg::ecdf_result_type           result;
   logic                                req_accept;
   logic                                out_free;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [ecdf_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [ecdf_pkg::VALUE_W-1:0]        rsp_x_ff, rsp_x_in;
   logic [ecdf_pkg::FRAC_W-1:0]         rsp_y_ff, rsp_y_in;
   logic                                rsp_last_ff, rsp_last_in;

   // Request handshake.
   assign req_if.ready = result.idle;
   assign req_accept   = req_if.valid && result.idle;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   ecdf_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .op           (req_if.op),
      .sample_value (req_if.sample_value),
      .out_free     (out_free),
      .div_req      (div_req),
      .div_rsp      (div_rsp),
      .result       (result)
   );

   ecdf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Response register, loaded when the sequencer finishes and the slot is free.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_last_in   = rsp_last_ff;
      if (result.fin && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = result.status;
         rsp_x_in      = result.point_x;
         rsp_y_in      = result.point_y;
         rsp_last_in   = result.last_point;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.status     = rsp_status_ff;
   assign rsp_if.point_x    = rsp_x_ff;
   assign rsp_if.point_y    = rsp_y_ff;
   assign rsp_if.last_point = rsp_last_ff;

   // An accepted request keeps the block busy in the following cycle.
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_accept, !req_if.ready)
   // Only a valid point can close the curve.
   `ASSERT_IMPLIES(a_last_is_ok, clock, reset, rsp_valid_ff && rsp_last_ff,
                   rsp_status_ff == ecdf_pkg::STATUS_OK)
   // Refused loads and exhausted reads carry no point.
   `ASSERT_IMPLIES(a_no_point_on_error, clock, reset,
                   rsp_valid_ff && rsp_status_ff != ecdf_pkg::STATUS_OK,
                   rsp_x_ff == '0 && rsp_y_ff == '0 && !rsp_last_ff)
   // The cumulative fraction never exceeds one.
   `ASSERT_IMPLIES(a_fraction_range, clock, reset, rsp_valid_ff,
                   rsp_y_ff <= ecdf_pkg::FRAC_W'(65536))

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the empirical CDF step-curve core.
module testbench;
   import ecdf_pkg::*;

   // The op code that the block ignores.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam int unsigned ITEM_TARGET  = 1650;
   localparam int unsigned FILL_READS   = 60;
   localparam int unsigned CYCLE_LIMIT  = 20_000_000;
   localparam int unsigned LONG_HOLD    = 500;
   localparam int unsigned TAIL_CYCLES  = 100;
   localparam int          DIRECTED_ROWS = 25;

   localparam logic [VALUE_W-1:0] VALUE_MIN  = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] VALUE_MAX  = 32'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0] VALUE_NEG1 = 32'hFFFF_FFFF;
   localparam logic [VALUE_W-1:0] VALUE_ONE  = 32'h0001_0000;

   typedef struct packed {
      ecdf_status_type    status;
      logic [VALUE_W-1:0] point_x;
      logic [FRAC_W-1:0]  point_y;
      logic               last_point;
   } curve_point_type;

   // One row of the directed table; want is used only when typed is set.
   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [VALUE_W-1:0] value;
      logic               typed;
      curve_point_type    want;
   } stim_row_type;

   localparam curve_point_type POINT_EMPTY    = '{STATUS_OK, '0, '0, 1'b0};
   localparam curve_point_type POINT_FULL     = '{STATUS_FULL, '0, '0, 1'b0};
   localparam curve_point_type POINT_DONE     = '{STATUS_DONE, '0, '0, 1'b0};
   localparam curve_point_type POINT_MIN_ZERO = '{STATUS_OK, VALUE_MIN, '0, 1'b0};

   // Directed part: empty table, ignored op, extreme values, a duplicate, a full
   // walk of the curve, a read past the end, a load that restarts the walk, a clear.
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{OP_READ,   32'h0,        1'b1, POINT_DONE},
      '{OP_UNUSED, VALUE_NEG1,   1'b1, POINT_EMPTY},
      '{OP_CLEAR,  32'h0,        1'b1, POINT_EMPTY},
      '{OP_LOAD,   VALUE_MIN,    1'b1, POINT_EMPTY},
      '{OP_LOAD,   VALUE_MAX,    1'b1, POINT_EMPTY},
      '{OP_LOAD,   32'h0,        1'b1, POINT_EMPTY},
      '{OP_LOAD,   32'h0,        1'b1, POINT_EMPTY},
      '{OP_LOAD,   VALUE_NEG1,   1'b1, POINT_EMPTY},
      '{OP_READ,   32'h0,        1'b1, POINT_MIN_ZERO},
      '{OP_READ,   VALUE_NEG1,   1'b0, POINT_EMPTY},
      '{OP_READ,   32'h0,        1'b0, POINT_EMPTY},
      '{OP_READ,   VALUE_NEG1,   1'b0, POINT_EMPTY},
      '{OP_READ,   32'h0,        1'b0, POINT_EMPTY},
      '{OP_READ,   VALUE_NEG1,   1'b0, POINT_EMPTY},
      '{OP_READ,   32'h0,        1'b0, POINT_EMPTY},
      '{OP_READ,   VALUE_NEG1,   1'b0, POINT_EMPTY},
      '{OP_READ,   32'h0,        1'b0, POINT_EMPTY},
      '{OP_READ,   VALUE_NEG1,   1'b0, POINT_EMPTY},
      '{OP_READ,   32'h0,        1'b0, POINT_EMPTY},
      '{OP_READ,   32'h0,        1'b1, POINT_DONE},
      '{OP_LOAD,   VALUE_ONE,    1'b1, POINT_EMPTY},
      '{OP_READ,   32'h0,        1'b1, POINT_MIN_ZERO},
      '{OP_READ,   32'h0,        1'b0, POINT_EMPTY},
      '{OP_CLEAR,  32'h0,        1'b1, POINT_EMPTY},
      '{OP_READ,   32'h0,        1'b1, POINT_DONE}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   ecdf_req_if req_ch ();
   ecdf_rsp_if rsp_ch ();

   empirical_cdf_step_curve_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow copy of the sorted table and of the curve walk.
   logic signed [VALUE_W-1:0] model_value [MAX_DISTINCT];
   logic [COUNT_W-1:0]        model_count [MAX_DISTINCT];
   int unsigned               model_used = 0;
   logic [COUNT_W-1:0]        model_total = '0;
   int unsigned               walk_index = 0;
   ecdf_phase_type            walk_phase = PH_PREV;
   logic [COUNT_W-1:0]        walk_count = '0;

   curve_point_type pending_points [$];
   curve_point_type oldest_point;
   int unsigned     mismatch_count = 0;
   int unsigned     responses_seen = 0;
   int unsigned     accepted_items = 0;
   int unsigned     cycle_count = 0;
   bit              long_hold_done = 1'b0;

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 90);
   endfunction

   // Cumulative fraction count * 65536 / total, rounded down.
   function automatic logic [FRAC_W-1:0] cdf_fraction(input logic [COUNT_W-1:0] count);
      logic [2*COUNT_W-1:0] scaled;
      scaled = {count, {COUNT_W{1'b0}}};
      if (model_total == '0) return '0;
      return FRAC_W'(scaled / {{COUNT_W{1'b0}}, model_total});
   endfunction

   function automatic void restart_walk();
      walk_index = 0;
      walk_phase = PH_PREV;
      walk_count = '0;
   endfunction

   // Sorted insert or count bump; a full total refuses all, a full table new values.
   function automatic ecdf_status_type apply_load(input logic signed [VALUE_W-1:0] sample);
      int unsigned pos;
      pos = 0;
      restart_walk();
      if (model_total == TOTAL_LIMIT) return STATUS_FULL;
      while (pos < model_used && model_value[pos] < sample) pos++;
      if (pos < model_used && model_value[pos] == sample) begin
         model_count[pos] = model_count[pos] + 1'b1;
         model_total = model_total + 1'b1;
         return STATUS_OK;
      end
      if (model_used >= MAX_DISTINCT) return STATUS_FULL;
      for (int unsigned k = model_used; k > pos; k--) begin
         model_value[k] = model_value[k-1];
         model_count[k] = model_count[k-1];
      end
      model_value[pos] = sample;
      model_count[pos] = COUNT_W'(1);
      model_used++;
      model_total = model_total + 1'b1;
      return STATUS_OK;
   endfunction

   // Expected response to one accepted request; updates the shadow state.
   function automatic curve_point_type next_curve_result(input logic [OP_W-1:0] op,
                                                         input logic [VALUE_W-1:0] value);
      curve_point_type point;
      point = POINT_EMPTY;
      case (op)
         OP_LOAD: point.status = apply_load(value);
         OP_CLEAR: begin
            model_used = 0;
            model_total = '0;
            restart_walk();
         end
         OP_READ: begin
            if (walk_index >= model_used) begin
               point.status = STATUS_DONE;
            end else begin
               case (walk_phase)
                  PH_PREV: begin
                     point.point_x = (walk_index == 0) ? model_value[0]
                                                       : model_value[walk_index-1];
                     point.point_y = cdf_fraction(walk_count);
                     walk_phase = PH_BEFORE;
                  end
                  PH_BEFORE: begin
                     point.point_x = model_value[walk_index];
                     point.point_y = cdf_fraction(walk_count);
                     if (walk_index + 1 == model_used) begin
                        // The closing step to one is not part of the curve.
                        point.last_point = 1'b1;
                        walk_index = model_used;
                        walk_phase = PH_PREV;
                     end else begin
                        walk_phase = PH_AFTER;
                     end
                  end
                  default: begin
                     walk_count = walk_count + model_count[walk_index];
                     point.point_x = model_value[walk_index];
                     point.point_y = cdf_fraction(walk_count);
                     walk_index++;
                     walk_phase = PH_PREV;
                  end
               endcase
            end
         end
         default: ;
      endcase
      return point;
   endfunction

   // Offer one request after a random gap and record its expected response.
   task automatic issue(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                        input logic typed, input curve_point_type typed_point);
      int unsigned     gap;
      curve_point_type point;
      curve_point_type expected;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.sample_value <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      point = next_curve_result(op, value);
      expected = typed ? typed_point : point;
      pending_points = {pending_points, expected};
      accepted_items++;
   endtask

   // Stop offering and wait until every expected response has arrived.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_points.size() > 0) @(posedge clock);
   endtask

   task automatic flag_mismatch(input string field, input logic [VALUE_W-1:0] got,
                                input logic [VALUE_W-1:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $time, field, got, want);
      mismatch_count++;
   endtask

   // Response checker: each accepted response against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         responses_seen <= responses_seen + 1;
         if (pending_points.size() == 0) begin
            flag_mismatch("unexpected response, status", VALUE_W'(rsp_ch.status), '0);
         end else begin
            oldest_point = pending_points.pop_front();
            if (rsp_ch.status !== oldest_point.status)
               flag_mismatch("status", VALUE_W'(rsp_ch.status),
                             VALUE_W'(oldest_point.status));
            if (rsp_ch.point_x !== oldest_point.point_x)
               flag_mismatch("point_x", rsp_ch.point_x, oldest_point.point_x);
            if (rsp_ch.point_y !== oldest_point.point_y)
               flag_mismatch("point_y", VALUE_W'(rsp_ch.point_y),
                             VALUE_W'(oldest_point.point_y));
            if (rsp_ch.last_point !== oldest_point.last_point)
               flag_mismatch("last_point", VALUE_W'(rsp_ch.last_point),
                             VALUE_W'(oldest_point.last_point));
         end
      end
   end

   // Receiver: random stalls, and once a long hold-off that backs up the block.
   initial begin
      int unsigned hold;
      int unsigned run;
      rsp_ch.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         hold = pick_gap();
         run = $urandom_range(1, 12);
         if (!long_hold_done && responses_seen >= 300) begin
            hold = LONG_HOLD;
            long_hold_done = 1'b1;
         end
         if (hold > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat (run) @(posedge clock);
      end
   end

   // Watchdog on the total run length.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   // Stimulus: directed table, then random sessions with one fill of the table.
   initial begin
      int unsigned                roll;
      int unsigned                loads;
      int unsigned                reads;
      bit                         wide;
      bit                         table_filled;
      logic [VALUE_W-1:0]         pool [6];

      table_filled = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.op = OP_LOAD;
      req_ch.sample_value = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++)
         issue(DIRECTED[r].op, DIRECTED[r].value, DIRECTED[r].typed, DIRECTED[r].want);

      while (accepted_items < ITEM_TARGET) begin
         roll = $urandom_range(0, 99);
         if (!table_filled && accepted_items >= 500) begin
            // Fill all entries, then a new value is refused while a known one still counts.
            wait_drained();
            issue(OP_CLEAR, $urandom(), 1'b1, POINT_EMPTY);
            while (model_used < MAX_DISTINCT)
               issue(OP_LOAD, $urandom() & ~32'h1, 1'b0, POINT_EMPTY);
            issue(OP_LOAD, $urandom() | 32'h1, 1'b1, POINT_FULL);
            issue(OP_LOAD, model_value[$urandom_range(0, MAX_DISTINCT - 1)], 1'b0, POINT_EMPTY);
            repeat (FILL_READS) issue(OP_READ, $urandom(), 1'b0, POINT_EMPTY);
            issue(OP_CLEAR, $urandom(), 1'b1, POINT_EMPTY);
            table_filled = 1'b1;
         end else if (roll < 78) begin
            // A well-formed session: mostly a clear, a run of loads, then the whole curve.
            wide = ($urandom_range(0, 9) < 3);
            for (int p = 0; p < 6; p++) begin
               if ($urandom_range(0, 4) == 0)
                  pool[p] = $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
               else
                  pool[p] = $urandom();
            end
            if ($urandom_range(0, 4) != 0) issue(OP_CLEAR, $urandom(), 1'b0, POINT_EMPTY);
            loads = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 10) : $urandom_range(11, 48);
            for (int n = 0; n < loads; n++) begin
               if ($urandom_range(0, 19) == 0) issue(OP_READ, $urandom(), 1'b0, POINT_EMPTY);
               issue(OP_LOAD, wide ? $urandom() : pool[$urandom_range(0, 5)],
                     1'b0, POINT_EMPTY);
            end
            reads = 3 * model_used;
            if ($urandom_range(0, 9) == 0) begin
               // Break off part way; the next load restarts the curve at its first point.
               repeat ($urandom_range(1, reads)) issue(OP_READ, $urandom(), 1'b0, POINT_EMPTY);
               issue(OP_LOAD, pool[$urandom_range(0, 5)], 1'b0, POINT_EMPTY);
               reads = 3 * model_used;
            end
            repeat (reads + $urandom_range(0, 1)) issue(OP_READ, $urandom(), 1'b0, POINT_EMPTY);
         end else if (roll < 93) begin
            // Noise: any op, the ignored one included, with random payloads.
            repeat ($urandom_range(8, 20))
               issue(OP_W'($urandom_range(0, 3)), $urandom(), 1'b0, POINT_EMPTY);
         end else begin
            wait_drained();
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
